### rtl/sha256_pkg.sv
// Shared types and constants of the SHA-256 byte stream hasher.
// Holds the sequencer state type, the round constants and the initial hash values.
// No dependencies.
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } t_state;

    // Eight 32-bit words; index 0 is word a (or H0), index 7 is word h (or H7).
    typedef logic [7:0][31:0] t_vars;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;
            default: v = 32'hc67178f2;
        endcase
        return v;
    endfunction

endpackage

### rtl/sha256_round.sv
// One SHA-256 compression round plus one message schedule expansion step.
// Purely combinational; the top level registers its results in the round state.
// Depends on sha256_pkg for the t_vars type.
module sha256_round (
    input  sha256_pkg::t_vars i_vars,
    input  logic [31:0]       i_k,
    input  logic [31:0]       i_w0,
    input  logic [31:0]       i_w1,
    input  logic [31:0]       i_w9,
    input  logic [31:0]       i_w14,
    output sha256_pkg::t_vars o_vars,
    output logic [31:0]       o_w_new
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] big0, big1, chs, maj, t1, t2, sig0, sig1;

    always_comb begin
        big1 = rotr(i_vars[4], 6) ^ rotr(i_vars[4], 11) ^ rotr(i_vars[4], 25);
        chs  = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        t1   = i_vars[7] + big1 + chs + i_k + i_w0;
        big0 = rotr(i_vars[0], 2) ^ rotr(i_vars[0], 13) ^ rotr(i_vars[0], 22);
        maj  = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
        t2   = big0 + maj;

        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;

        // Word sixteen places ahead of the one consumed in this round.
        sig0    = rotr(i_w1, 7) ^ rotr(i_w1, 18) ^ (i_w1 >> 3);
        sig1    = rotr(i_w14, 17) ^ rotr(i_w14, 19) ^ (i_w14 >> 10);
        o_w_new = i_w0 + sig0 + i_w9 + sig1;
    end

endmodule

### rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 over a byte stream: one byte per transfer, digest out as eight words.
// A byte that does not fill a block is only stored; a byte that fills one starts
// 64 rounds on the shared round unit and one hash update, while input is not ready.
// End of message: the pad bytes are pushed, each full block hashed, then 8 word transfers.
// Reset (synchronous, active low) loads the initial hash values and empties the block.
// Depends on sha256_pkg and sha256_round.
module sha256_byte_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_state r_state, n_state;
    logic [5:0]         r_round, n_round;
    logic [5:0]         r_count, n_count;
    logic [63:0]        r_bits, n_bits;
    logic [511:0]       r_blk, n_blk;
    sha256_pkg::t_vars  r_hash, n_hash;
    sha256_pkg::t_vars  r_vars, n_vars;
    logic [2:0]         r_out_idx, n_out_idx;
    logic               r_padding, n_padding;
    logic               r_mark_done, n_mark_done;
    logic               r_len_phase, n_len_phase;
    logic               r_final, n_final;

    logic               push_en;
    logic [7:0]         push_byte;
    sha256_pkg::t_vars  rnd_vars;
    logic [31:0]        rnd_w_new;

    // The block buffer doubles as the rolling 16-word schedule window; word 0 sits on top.
    sha256_round u_round (
        .i_vars  (r_vars),
        .i_k     (sha256_pkg::round_const(r_round)),
        .i_w0    (r_blk[511:480]),
        .i_w1    (r_blk[479:448]),
        .i_w9    (r_blk[223:192]),
        .i_w14   (r_blk[63:32]),
        .o_vars  (rnd_vars),
        .o_w_new (rnd_w_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha256_pkg::ST_IDLE;
            r_round     <= '0;
            r_count     <= '0;
            r_bits      <= '0;
            r_out_idx   <= '0;
            r_padding   <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_phase <= 1'b0;
            r_final     <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_hash[i] <= sha256_pkg::init_hash(3'(i));
            end
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_count     <= n_count;
            r_bits      <= n_bits;
            r_out_idx   <= n_out_idx;
            r_padding   <= n_padding;
            r_mark_done <= n_mark_done;
            r_len_phase <= n_len_phase;
            r_final     <= n_final;
            r_hash      <= n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_vars <= n_vars;
    end

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_count     = r_count;
        n_bits      = r_bits;
        n_blk       = r_blk;
        n_hash      = r_hash;
        n_vars      = r_vars;
        n_out_idx   = r_out_idx;
        n_padding   = r_padding;
        n_mark_done = r_mark_done;
        n_len_phase = r_len_phase;
        n_final     = r_final;
        push_en     = 1'b0;
        push_byte   = '0;
        o_ready     = 1'b0;
        o_valid     = 1'b0;

        case (r_state)
            sha256_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_has_byte) begin
                        push_en   = 1'b1;
                        push_byte = i_data_byte;
                        n_bits    = r_bits + sha256_pkg::BITS_PER_BYTE;
                    end
                    if (i_end_of_message) begin
                        n_padding = 1'b1;
                        n_state   = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                push_en = 1'b1;
                if (!r_mark_done) begin
                    push_byte   = sha256_pkg::PAD_MARK;
                    n_mark_done = 1'b1;
                end else if (r_len_phase || r_count == sha256_pkg::LEN_OFFSET) begin
                    // Length bytes go out most significant first at offsets 56 to 63.
                    push_byte   = r_bits[{~r_count[2:0], 3'b000} +: 8];
                    n_len_phase = 1'b1;
                    if (r_count == sha256_pkg::LAST_POS) begin
                        n_final = 1'b1;
                    end
                end else begin
                    push_byte = '0;
                end
            end
            sha256_pkg::ST_ROUND: begin
                n_vars  = rnd_vars;
                n_blk   = {r_blk[479:0], rnd_w_new};
                n_round = r_round + 6'd1;
                if (r_round == sha256_pkg::LAST_ROUND) begin
                    n_state = sha256_pkg::ST_ADD;
                end
            end
            sha256_pkg::ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_hash[i] = r_hash[i] + r_vars[i];
                end
                if (r_final) begin
                    n_state = sha256_pkg::ST_OUT;
                end else if (r_padding) begin
                    n_state = sha256_pkg::ST_PAD;
                end else begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == sha256_pkg::LAST_WORD) begin
                        // Digest delivered: start over for the next message.
                        n_state     = sha256_pkg::ST_IDLE;
                        n_bits      = '0;
                        n_padding   = 1'b0;
                        n_mark_done = 1'b0;
                        n_len_phase = 1'b0;
                        n_final     = 1'b0;
                        for (int i = 0; i < 8; i++) begin
                            n_hash[i] = sha256_pkg::init_hash(3'(i));
                        end
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase

        if (push_en) begin
            n_blk   = {r_blk[503:0], push_byte};
            n_count = r_count + 6'd1;
            if (r_count == sha256_pkg::LAST_POS) begin
                // Block complete: load the working words and run the rounds.
                n_state = sha256_pkg::ST_ROUND;
                n_round = '0;
                n_vars  = r_hash;
            end
        end
    end

    assign o_digest_word = r_hash[r_out_idx];
    assign o_word_index  = r_out_idx;
    assign o_last_word   = (r_out_idx == sha256_pkg::LAST_WORD);

endmodule

### rtl/sha256_chk.sv
// Port-level checks for the SHA-256 byte stream hasher, bound to its top level.
// Depends on sha256_byte_stream_hasher_top.
module sha256_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // A stalled digest word holds its value and position.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("digest word changed while stalled");

    // No new byte is taken while the digest is being delivered.
    a_no_input_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while digest pending");

    // Words of one digest follow in order without gaps.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_word |=>
            o_valid && o_word_index == 3'($past(o_word_index) + 3'd1))
        else $error("digest word skipped or repeated");

    // The last flag marks exactly the eighth word, after which output goes quiet.
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_word |-> o_word_index == 3'd7 ##1 !o_valid)
        else $error("digest ended at the wrong word");

endmodule

bind sha256_byte_stream_hasher_top sha256_chk u_sha256_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_index  (o_word_index),
    .o_last_word   (o_last_word)
);
